// ----- sv/tfn_pkg.sv -----
// ----------------------------------------------------------------------------
// Triangle face normal package
// Word types, pipeline payload types and depth constants shared by the unit.
// ----------------------------------------------------------------------------
package tfn_pkg;

   localparam int SQRT_STAGES = 32;
   localparam int DIV_STAGES  = 15;
   localparam int SCALE_TOP   = 30;

   typedef struct packed {
      logic signed [15:0] first_x;
      logic signed [15:0] first_y;
      logic signed [15:0] first_z;
      logic signed [15:0] second_x;
      logic signed [15:0] second_y;
      logic signed [15:0] second_z;
      logic signed [15:0] third_x;
      logic signed [15:0] third_y;
      logic signed [15:0] third_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic               degenerate;
   } rsp_type;

   typedef struct packed {
      logic signed [34:0] cx;
      logic signed [34:0] cy;
      logic signed [34:0] cz;
   } cross_type;

   typedef struct packed {
      logic [2:0][30:0] mag;
      logic [2:0]       neg;
      logic             degen;
   } scaled_type;

   typedef struct packed {
      logic [2:0][30:0] mag;
      logic [2:0]       neg;
      logic             degen;
      logic [31:0]      len;
   } norm_type;

   typedef struct packed {
      logic [2:0][14:0] q;
      logic [2:0]       neg;
      logic             degen;
   } quot_type;

endpackage

// ----- sv/tfn_cross.sv -----
// ----------------------------------------------------------------------------
// Edge and cross product stages
// Forms both edges, the partial products and from them the cross product.
// ----------------------------------------------------------------------------
module tfn_cross (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  tfn_pkg::req_type   in_data,
   output logic               out_valid,
   output tfn_pkg::cross_type out_data
);
   import tfn_pkg::*;

   logic signed [16:0] ux_ff, uy_ff, uz_ff, vx_ff, vy_ff, vz_ff;
   logic signed [33:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   cross_type          c_ff;
   logic [2:0]         v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ux_ff <= 17'(in_data.second_x) - 17'(in_data.first_x);
         uy_ff <= 17'(in_data.second_y) - 17'(in_data.first_y);
         uz_ff <= 17'(in_data.second_z) - 17'(in_data.first_z);
         vx_ff <= 17'(in_data.third_x) - 17'(in_data.first_x);
         vy_ff <= 17'(in_data.third_y) - 17'(in_data.first_y);
         vz_ff <= 17'(in_data.third_z) - 17'(in_data.first_z);
         p0_ff <= uy_ff * vz_ff;
         p1_ff <= uz_ff * vy_ff;
         p2_ff <= uz_ff * vx_ff;
         p3_ff <= ux_ff * vz_ff;
         p4_ff <= ux_ff * vy_ff;
         p5_ff <= uy_ff * vx_ff;
         c_ff.cx <= 35'(p0_ff) - 35'(p1_ff);
         c_ff.cy <= 35'(p2_ff) - 35'(p3_ff);
         c_ff.cz <= 35'(p4_ff) - 35'(p5_ff);
      end
   end

   assign out_valid = v_ff[2];
   assign out_data  = c_ff;
endmodule

// ----- sv/tfn_scale.sv -----
// ----------------------------------------------------------------------------
// Block scaling stages
// Splits sign and magnitude, finds the top set bit and scales the magnitudes
// so that the largest one has its top bit at bit 30.
// ----------------------------------------------------------------------------
module tfn_scale (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  tfn_pkg::cross_type  in_data,
   output logic                out_valid,
   output tfn_pkg::scaled_type out_data
);
   import tfn_pkg::*;

   logic [2:0][34:0] mag_in;
   logic [34:0]      or_in;
   logic [2:0][34:0] mag_ff, mag2_ff;
   logic [2:0]       neg_ff, neg2_ff;
   logic [34:0]      or_ff;
   logic [5:0]       top_in, top_ff;
   logic             zero_ff;
   scaled_type       s_in, s_ff;
   logic [2:0]       v_ff;

   always_comb begin
      top_in = '0;
      for (int i = 0; i < 35; i++) begin
         if (or_ff[i]) begin
            top_in = 6'(i);
         end
      end
   end

   always_comb begin
      s_in.neg   = neg2_ff;
      s_in.degen = zero_ff;
      for (int c = 0; c < 3; c++) begin
         if (top_ff > 6'(SCALE_TOP)) begin
            s_in.mag[c] = 31'(mag2_ff[c] >> (top_ff - 6'(SCALE_TOP)));
         end else begin
            s_in.mag[c] = 31'(mag2_ff[c] << (6'(SCALE_TOP) - top_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff    <= {in_data.cz[34], in_data.cy[34], in_data.cx[34]};
         mag_ff    <= mag_in;
         or_ff     <= or_in;
         mag2_ff   <= mag_ff;
         neg2_ff   <= neg_ff;
         top_ff    <= top_in;
         zero_ff   <= (or_ff == '0);
         s_ff      <= s_in;
      end
   end

   // The OR of the magnitudes has its top bit where the largest one has.
   always_comb begin
      mag_in[0] = in_data.cx[34] ? 35'(-in_data.cx) : 35'(in_data.cx);
      mag_in[1] = in_data.cy[34] ? 35'(-in_data.cy) : 35'(in_data.cy);
      mag_in[2] = in_data.cz[34] ? 35'(-in_data.cz) : 35'(in_data.cz);
      or_in     = mag_in[0] | mag_in[1] | mag_in[2];
   end

   assign out_valid = v_ff[2];
   assign out_data  = s_ff;
endmodule

// ----- sv/tfn_isqrt.sv -----
// ----------------------------------------------------------------------------
// Length stages
// Squares and sums the scaled magnitudes, then takes the integer square root
// one result bit per stage.
// ----------------------------------------------------------------------------
module tfn_isqrt (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  tfn_pkg::scaled_type in_data,
   output logic                out_valid,
   output tfn_pkg::norm_type   out_data
);
   import tfn_pkg::*;

   logic [2:0][61:0] sq_ff;
   scaled_type       sq_pay_ff;
   logic             sq_v_ff;
   logic [63:0]      x_ff   [0:SQRT_STAGES];
   logic [63:0]      res_ff [0:SQRT_STAGES];
   scaled_type       pay_ff [0:SQRT_STAGES];
   logic             v_ff   [0:SQRT_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff  <= 1'b0;
         v_ff[0]  <= 1'b0;
      end else if (en) begin
         sq_v_ff  <= in_valid;
         v_ff[0]  <= sq_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            sq_ff[c] <= 62'(in_data.mag[c]) * 62'(in_data.mag[c]);
         end
         sq_pay_ff  <= in_data;
         x_ff[0]    <= 64'(sq_ff[0]) + 64'(sq_ff[1]) + 64'(sq_ff[2]);
         res_ff[0]  <= '0;
         pay_ff[0]  <= sq_pay_ff;
      end
   end

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_root
      localparam logic [64:0] BitVal = 65'd1 << (62 - 2 * k);
      logic [64:0] trial;
      logic        take;

      assign trial = 65'(res_ff[k]) + BitVal;
      assign take  = (65'(x_ff[k]) >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            pay_ff[k+1] <= pay_ff[k];
            if (take) begin
               x_ff[k+1]   <= 64'(65'(x_ff[k]) - trial);
               res_ff[k+1] <= 64'((65'(res_ff[k]) >> 1) + BitVal);
            end else begin
               x_ff[k+1]   <= x_ff[k];
               res_ff[k+1] <= res_ff[k] >> 1;
            end
         end
      end
   end

   always_comb begin
      out_data.mag   = pay_ff[SQRT_STAGES].mag;
      out_data.neg   = pay_ff[SQRT_STAGES].neg;
      out_data.degen = pay_ff[SQRT_STAGES].degen;
      out_data.len   = res_ff[SQRT_STAGES][31:0];
   end

   assign out_valid = v_ff[SQRT_STAGES];
endmodule

// ----- sv/tfn_div.sv -----
// ----------------------------------------------------------------------------
// Normalizing divider stages
// Divides each scaled magnitude by the length, rounded half up, with one
// quotient bit per stage for all three components side by side.
// ----------------------------------------------------------------------------
module tfn_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  tfn_pkg::norm_type in_data,
   output logic              out_valid,
   output tfn_pkg::quot_type out_data
);
   import tfn_pkg::*;

   logic [2:0][46:0] rem_ff [0:DIV_STAGES];
   logic [2:0][14:0] q_ff   [0:DIV_STAGES];
   logic [32:0]      d_ff   [0:DIV_STAGES];
   logic [2:0]       neg_ff [0:DIV_STAGES];
   logic             dg_ff  [0:DIV_STAGES];
   logic             v_ff   [0:DIV_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   // The numerator is the magnitude times 2^15 plus the length, over twice
   // the length.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            rem_ff[0][c] <= {1'b0, in_data.mag[c], 15'd0} + 47'(in_data.len);
         end
         q_ff[0]   <= '0;
         d_ff[0]   <= {in_data.len, 1'b0};
         neg_ff[0] <= in_data.neg;
         dg_ff[0]  <= in_data.degen;
      end
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
      localparam int Sh = DIV_STAGES - 1 - k;
      logic [47:0]      dsh;
      logic [2:0][46:0] rem_in;
      logic [2:0][14:0] q_in;

      assign dsh = 48'(d_ff[k]) << Sh;

      always_comb begin
         for (int c = 0; c < 3; c++) begin
            rem_in[c] = rem_ff[k][c];
            q_in[c]   = q_ff[k][c];
            if (48'(rem_ff[k][c]) >= dsh) begin
               rem_in[c]    = 47'(48'(rem_ff[k][c]) - dsh);
               q_in[c][Sh]  = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= rem_in;
            q_ff[k+1]   <= q_in;
            d_ff[k+1]   <= d_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            dg_ff[k+1]  <= dg_ff[k];
         end
      end
   end

   always_comb begin
      out_data.q     = q_ff[DIV_STAGES];
      out_data.neg   = neg_ff[DIV_STAGES];
      out_data.degen = dg_ff[DIV_STAGES];
   end

   assign out_valid = v_ff[DIV_STAGES];
endmodule

// ----- sv/triangle_face_normal_unit.sv -----
// ----------------------------------------------------------------------------
// Triangle face normal unit
// Unit face normal of a triangle: the cross product of the edges from the first vertex, normalized.
// ----------------------------------------------------------------------------
// Usage: a triangle word (three Q8.8 vertices) enters on req_valid while
// req_stall is low. Each word gives exactly one result word on rsp_: the unit
// normal in Q1.14, saturated to one, and a degenerate flag that is set, with
// an all-zero normal, when the cross product is zero.
// From acceptance to rsp_valid the pipeline has three stages for the edges
// and cross product, three for block scaling, two for the squared length,
// 32 for the square root (one bit a stage), 16 for the division (a setup
// stage, then one quotient bit a stage) and the output register.
// Throughput is a word per cycle unless stalled; triangles are independent.
// Reset clears the valid bits of every stage and of the output register.
// When rsp_stall holds a waiting result, the whole pipeline freezes and
// req_stall rises in the same cycle, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module triangle_face_normal_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tfn_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tfn_pkg::rsp_type rsp_data
);
   import tfn_pkg::*;

   logic       en;
   logic       cr_v, sc_v, nm_v, qt_v;
   cross_type  cr_d;
   scaled_type sc_d;
   norm_type   nm_d;
   quot_type   qt_d;
   rsp_type    rsp_in, rsp_ff;
   logic       rsp_valid_ff;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   tfn_cross u_cross (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_valid && !req_stall), .in_data(req_data),
      .out_valid(cr_v), .out_data(cr_d)
   );

   tfn_scale u_scale (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(cr_v), .in_data(cr_d),
      .out_valid(sc_v), .out_data(sc_d)
   );

   tfn_isqrt u_isqrt (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(sc_v), .in_data(sc_d),
      .out_valid(nm_v), .out_data(nm_d)
   );

   tfn_div u_div (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(nm_v), .in_data(nm_d),
      .out_valid(qt_v), .out_data(qt_d)
   );

   always_comb begin
      logic [2:0][15:0] comp;
      logic [15:0]      sat;
      for (int c = 0; c < 3; c++) begin
         sat = (qt_d.q[c] > 15'd16384) ? 16'd16384 : 16'(qt_d.q[c]);
         if (qt_d.degen) begin
            comp[c] = '0;
         end else if (qt_d.neg[c]) begin
            comp[c] = 16'(-sat);
         end else begin
            comp[c] = sat;
         end
      end
      rsp_in.normal_x   = comp[0];
      rsp_in.normal_y   = comp[1];
      rsp_in.normal_z   = comp[2];
      rsp_in.degenerate = qt_d.degen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= qt_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
